// ===== rtl/btff_pkg.sv =====
// shared constants and status codes for the boundary-tag allocator
`timescale 1ns / 1ps
package btff_pkg;

  // default pool geometry
  localparam int unsigned POOL_WORDS_DEF = 65536;
  localparam int unsigned MIN_CHUNK_DEF  = 3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NULL     = 3'd1;
  localparam logic [2:0] ST_OOM      = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_BAD_FREE = 3'd4;

  // request function codes
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

endpackage

// ===== rtl/btff_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module btff_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/boundary_tag_first_fit_allocator.sv =====
// top level: boundary-tag first-fit allocator sequencer around the tag ram
`timescale 1ns / 1ps
// Command-style allocator over a pool of POOL_WORDS tag words held in one
// synchronous ram. A request is taken when start is high and busy is low;
// its single result appears on the out_ ports for exactly one cycle with
// out_valid high and cannot be held off. The walk visits every chunk on the
// chain from word 0 (one tag read per cycle); an allocate then makes 2 or 4
// tag writes, and a free walks the chunks before it, then does the tag checks
// and both merges. Each step ends with a read of word 0 to report heap_empty.
// After reset the block stays busy while it writes the two boundary tags of
// the initial free chunk.
module boundary_tag_first_fit_allocator #(
  parameter int unsigned POOL_WORDS = btff_pkg::POOL_WORDS_DEF,
  parameter int unsigned MIN_CHUNK  = btff_pkg::MIN_CHUNK_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [17:0] in_request_bytes,
  input  logic [16:0] in_free_addr,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_data_addr,
  output logic        out_heap_empty
);

  localparam int unsigned AW = $clog2(POOL_WORDS);
  // value width: holds signed tags, request sizes and addresses past the pool
  localparam int unsigned VW = ((AW > 16) ? AW : 16) + 2;
  localparam logic [VW-1:0] NV   = VW'(POOL_WORDS);
  localparam logic [VW-1:0] MINV = VW'(MIN_CHUNK);
  localparam logic [VW-1:0] TWO  = VW'(2);
  localparam logic [VW-1:0] ONE  = VW'(1);

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_IDLE, S_WALK,
    S_AW1, S_AW2, S_AW3, S_AW4,
    S_F_TOP, S_F_WTOP, S_F_NXT, S_F_NXTW,
    S_F_PRV, S_F_PTOP, S_F_PBOT, S_F_PN, S_F_PNW,
    S_EMP_RD, S_EMP_CHK
  } state_t;

  state_t          state_r, state_nxt;
  logic            func_r, func_nxt;
  logic            split_r, split_nxt;
  logic [VW-1:0]   size_r, size_nxt;
  logic [VW-1:0]   c_r, c_nxt;
  logic [VW-1:0]   w_r, w_nxt;
  logic [VW-1:0]   t_r, t_nxt;
  logic [VW-1:0]   n_r, n_nxt;
  logic [VW-1:0]   p_r, p_nxt;
  logic [2:0]      status_r, status_nxt;
  logic [15:0]     data_r, data_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_status_r, out_status_nxt;
  logic [15:0]     out_data_addr_r, out_data_addr_nxt;
  logic            out_heap_empty_r, out_heap_empty_nxt;

  // ram side
  logic            wr_en;
  logic [VW-1:0]   wr_addr_v;
  logic [VW-1:0]   wr_data_v;
  logic [VW-1:0]   rd_addr_v;
  logic [VW-1:0]   rd_data;

  // helpers on the read data
  logic [VW-1:0]   tmag;
  logic [VW-1:0]   next_w;
  logic [VW-1:0]   req_words;
  logic [VW-1:0]   faddr_m1;
  logic [VW-1:0]   sum_new;

  btff_ram #(
    .WIDTH (VW),
    .DEPTH (POOL_WORDS)
  ) u_tags (
    .clk     (clk),
    .wr_en   (wr_en && (wr_addr_v < NV)),
    .wr_addr (wr_addr_v[AW-1:0]),
    .wr_data (wr_data_v),
    .rd_addr (rd_addr_v[AW-1:0]),
    .rd_data (rd_data)
  );

  // magnitude of the tag just read and the chunk that follows it
  assign tmag      = rd_data[VW-1] ? (~rd_data + ONE) : rd_data;
  assign next_w    = w_r + tmag + TWO;
  assign req_words = VW'(({1'b0, in_request_bytes} + 19'd3) >> 2);
  assign faddr_m1  = VW'(in_free_addr) - ONE;

  // sequencer next state
  always_comb begin
    state_nxt          = state_r;
    func_nxt           = func_r;
    split_nxt          = split_r;
    size_nxt           = size_r;
    c_nxt              = c_r;
    w_nxt              = w_r;
    t_nxt              = t_r;
    n_nxt              = n_r;
    p_nxt              = p_r;
    status_nxt         = status_r;
    data_nxt           = data_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = out_status_r;
    out_data_addr_nxt  = out_data_addr_r;
    out_heap_empty_nxt = out_heap_empty_r;
    wr_en              = 1'b0;
    wr_addr_v          = '0;
    wr_data_v          = '0;
    rd_addr_v          = '0;
    sum_new            = '0;

    case (state_r)
      // boundary tags of the initial free chunk
      S_INIT0: begin
        wr_en     = 1'b1;
        wr_addr_v = '0;
        wr_data_v = NV - TWO;
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        wr_en     = 1'b1;
        wr_addr_v = NV - ONE;
        wr_data_v = NV - TWO;
        state_nxt = S_IDLE;
      end

      // take a request and start the walk at word 0 (a null or ignored request goes straight to the empty check)
      S_IDLE: begin
        if (start) begin
          func_nxt   = in_func;
          size_nxt   = req_words;
          c_nxt      = faddr_m1;
          w_nxt      = '0;
          status_nxt = btff_pkg::ST_OK;
          data_nxt   = '0;
          if (in_func == btff_pkg::FN_ALLOC) begin
            if (in_request_bytes == '0) begin
              status_nxt = btff_pkg::ST_NULL;
              state_nxt  = S_EMP_RD;
            end else begin
              state_nxt = S_WALK;
            end
          end else begin
            if (in_free_addr == '0 || faddr_m1 >= NV) begin
              status_nxt = btff_pkg::ST_IGNORED;
              state_nxt  = S_EMP_RD;
            end else begin
              state_nxt = S_WALK;
            end
          end
        end
      end

      // one chunk per cycle: rd_data is the bottom tag at w_r
      S_WALK: begin
        if (func_r == btff_pkg::FN_ALLOC) begin
          if ($signed(rd_data) < $signed(size_r)) begin
            if (next_w >= NV) begin
              status_nxt = btff_pkg::ST_OOM;
              state_nxt  = S_EMP_RD;
            end else begin
              w_nxt     = next_w;
              rd_addr_v = next_w;
            end
          end else begin
            c_nxt    = w_r;
            data_nxt = 16'(w_r + ONE);
            if ($signed(rd_data) > $signed(size_r + MINV)) begin
              split_nxt = 1'b1;
              t_nxt     = size_r;
              n_nxt     = rd_data - size_r - TWO;
            end else begin
              split_nxt = 1'b0;
              t_nxt     = rd_data;
            end
            state_nxt = S_AW1;
          end
        end else begin
          if (w_r < c_r) begin
            if (next_w >= NV) begin
              status_nxt = btff_pkg::ST_BAD_FREE;
              state_nxt  = S_EMP_RD;
            end else begin
              w_nxt     = next_w;
              rd_addr_v = next_w;
            end
          end else if (w_r != c_r || !rd_data[VW-1] || (c_r + ONE + tmag) >= NV) begin
            status_nxt = btff_pkg::ST_BAD_FREE;
            state_nxt  = S_EMP_RD;
          end else begin
            t_nxt     = rd_data;
            rd_addr_v = c_r + ONE + tmag;
            state_nxt = S_F_TOP;
          end
        end
      end

      // allocate: mark used, optionally split off the spare part
      S_AW1: begin
        wr_en     = 1'b1;
        wr_addr_v = c_r;
        wr_data_v = ~t_r + ONE;
        state_nxt = S_AW2;
      end
      S_AW2: begin
        wr_en     = 1'b1;
        wr_addr_v = c_r + ONE + t_r;
        wr_data_v = ~t_r + ONE;
        state_nxt = split_r ? S_AW3 : S_EMP_RD;
      end
      S_AW3: begin
        wr_en     = 1'b1;
        wr_addr_v = c_r + t_r + TWO;
        wr_data_v = n_r;
        state_nxt = S_AW4;
      end
      S_AW4: begin
        wr_en     = 1'b1;
        wr_addr_v = c_r + t_r + TWO + ONE + n_r;
        wr_data_v = n_r;
        state_nxt = S_EMP_RD;
      end

      // free: top tag must match the bottom one
      S_F_TOP: begin
        if (rd_data != t_r) begin
          status_nxt = btff_pkg::ST_BAD_FREE;
          state_nxt  = S_EMP_RD;
        end else begin
          wr_en     = 1'b1;
          wr_addr_v = c_r;
          wr_data_v = ~t_r + ONE;
          t_nxt     = ~t_r + ONE;
          state_nxt = S_F_WTOP;
        end
      end
      S_F_WTOP: begin
        wr_en     = 1'b1;
        wr_addr_v = c_r + ONE + t_r;
        wr_data_v = t_r;
        if ((c_r + TWO + t_r) < NV) begin
          rd_addr_v = c_r + TWO + t_r;
          state_nxt = S_F_NXT;
        end else begin
          state_nxt = S_F_PRV;
        end
      end

      // merge with a free successor
      S_F_NXT: begin
        if (!rd_data[VW-1] && rd_data != '0) begin
          sum_new   = t_r + rd_data + TWO;
          wr_en     = 1'b1;
          wr_addr_v = c_r;
          wr_data_v = sum_new;
          t_nxt     = sum_new;
          state_nxt = S_F_NXTW;
        end else begin
          state_nxt = S_F_PRV;
        end
      end
      S_F_NXTW: begin
        wr_en     = 1'b1;
        wr_addr_v = c_r + ONE + t_r;
        wr_data_v = t_r;
        state_nxt = S_F_PRV;
      end

      // find the predecessor through its top tag
      S_F_PRV: begin
        if (c_r != '0) begin
          rd_addr_v = c_r - ONE;
          state_nxt = S_F_PTOP;
        end else begin
          state_nxt = S_EMP_RD;
        end
      end
      S_F_PTOP: begin
        p_nxt     = c_r - TWO - tmag;
        rd_addr_v = c_r - TWO - tmag;
        state_nxt = S_F_PBOT;
      end
      S_F_PBOT: begin
        if (rd_data[VW-1] || (p_r + tmag + TWO) >= NV) begin
          state_nxt = S_EMP_RD;
        end else begin
          n_nxt     = rd_data;
          rd_addr_v = p_r + tmag + TWO;
          state_nxt = S_F_PN;
        end
      end
      S_F_PN: begin
        if (!rd_data[VW-1] && rd_data != '0) begin
          sum_new   = n_r + rd_data + TWO;
          wr_en     = 1'b1;
          wr_addr_v = p_r;
          wr_data_v = sum_new;
          n_nxt     = sum_new;
          state_nxt = S_F_PNW;
        end else begin
          state_nxt = S_EMP_RD;
        end
      end
      S_F_PNW: begin
        wr_en     = 1'b1;
        wr_addr_v = p_r + ONE + n_r;
        wr_data_v = n_r;
        state_nxt = S_EMP_RD;
      end

      // pool-empty check on word 0, then the result beat
      S_EMP_RD: begin
        rd_addr_v = '0;
        state_nxt = S_EMP_CHK;
      end
      S_EMP_CHK: begin
        out_valid_nxt      = 1'b1;
        out_status_nxt     = status_r;
        out_data_addr_nxt  = data_r;
        out_heap_empty_nxt = !rd_data[VW-1] && rd_data != '0 && (rd_data + TWO) == NV;
        state_nxt          = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r           <= func_nxt;
    split_r          <= split_nxt;
    size_r           <= size_nxt;
    c_r              <= c_nxt;
    w_r              <= w_nxt;
    t_r              <= t_nxt;
    n_r              <= n_nxt;
    p_r              <= p_nxt;
    status_r         <= status_nxt;
    data_r           <= data_nxt;
    out_status_r     <= out_status_nxt;
    out_data_addr_r  <= out_data_addr_nxt;
    out_heap_empty_r <= out_heap_empty_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_addr  = out_data_addr_r;
  assign out_heap_empty = out_heap_empty_r;

endmodule
